/* rtl/core/topq_pkg.sv */
// Shared types and constants for the time-ordered priority queue.
package topq_pkg;

  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int PARTY_W = 8;
  localparam int TAG_W   = 16;
  localparam int OCC_W   = 5;
  localparam int KEY_W   = HOUR_W + MIN_W;

  localparam logic [HOUR_W-1:0] MAX_HOUR   = 5'd23;
  localparam logic [MIN_W-1:0]  MAX_MINUTE = 6'd59;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TIME = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef logic [KEY_W-1:0] key_t;

  // One stored customer entry.
  typedef struct packed {
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [PARTY_W-1:0] party;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  // A classified operation passed from the front end to the back end.
  typedef struct packed {
    cmd_t   cmd;
    logic   bad_time;
    entry_t entry;
  } op_t;

  // Sort key: hour in the upper bits, minute in the lower bits.
  function automatic key_t time_key(entry_t e);
    return {e.hour, e.minute};
  endfunction

endpackage

/* rtl/core/time_ordered_priority_queue.sv */
// Top level of the time-ordered priority queue.
// Words pass the two-entry operation queue, the operation register, the compare step
// and the shift step over the sorted entry register row into the result register; the
// next word is taken as one executes unless out_ready stalls. Synchronous active-low
// reset empties the queue, but clears no entry; only stored entries are ever read.
module time_ordered_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [topq_pkg::HOUR_W-1:0]   in_arrival_hour,
  input  logic [topq_pkg::MIN_W-1:0]    in_arrival_minute,
  input  logic [topq_pkg::PARTY_W-1:0]  in_party_size,
  input  logic [topq_pkg::TAG_W-1:0]    in_customer_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [topq_pkg::HOUR_W-1:0]   out_hour,
  output logic [topq_pkg::MIN_W-1:0]    out_minute,
  output logic [topq_pkg::PARTY_W-1:0]  out_party_size,
  output logic [topq_pkg::TAG_W-1:0]    out_tag,
  output logic [topq_pkg::OCC_W-1:0]    out_occupancy
);
  import topq_pkg::*;

  logic q_valid;
  logic q_ready;
  op_t  q_op;

  // Input check and operation queue.
  topq_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_arrival_hour   (in_arrival_hour),
    .in_arrival_minute (in_arrival_minute),
    .in_party_size     (in_party_size),
    .in_customer_tag   (in_customer_tag),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_op              (q_op)
  );

  // Sorted store and result register.
  topq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_op           (q_op),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_hour       (out_hour),
    .out_minute     (out_minute),
    .out_party_size (out_party_size),
    .out_tag        (out_tag),
    .out_occupancy  (out_occupancy)
  );

endmodule

/* rtl/core/topq_front.sv */
// Front end: accepts input words, checks the arrival time and queues operations.
module topq_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_command,
  input  logic [topq_pkg::HOUR_W-1:0]     in_arrival_hour,
  input  logic [topq_pkg::MIN_W-1:0]      in_arrival_minute,
  input  logic [topq_pkg::PARTY_W-1:0]    in_party_size,
  input  logic [topq_pkg::TAG_W-1:0]      in_customer_tag,
  output logic                            q_valid,
  input  logic                            q_ready,
  output topq_pkg::op_t                   q_op
);
  import topq_pkg::*;

  op_t        slot_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] fill_r;
  logic [1:0] fill_nxt;
  op_t        op_in;
  logic       push;
  logic       pop;

  // Classify the incoming word; the time check only matters for an enqueue.
  always_comb begin
    op_in.cmd          = cmd_t'(in_command);
    op_in.entry.hour   = in_arrival_hour;
    op_in.entry.minute = in_arrival_minute;
    op_in.entry.party  = in_party_size;
    op_in.entry.tag    = in_customer_tag;
    op_in.bad_time     = (in_arrival_hour > MAX_HOUR) || (in_arrival_minute > MAX_MINUTE);
  end

  // Two-entry queue handshakes.
  assign in_ready = (fill_r != 2'd2);
  assign q_valid  = (fill_r != 2'd0);
  assign q_op     = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

/* rtl/core/topq_back.sv */
// Back end: sorted entry store with compare and shift steps and the result register.
module topq_back #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  topq_pkg::op_t                 q_op,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [topq_pkg::HOUR_W-1:0]   out_hour,
  output logic [topq_pkg::MIN_W-1:0]    out_minute,
  output logic [topq_pkg::PARTY_W-1:0]  out_party_size,
  output logic [topq_pkg::TAG_W-1:0]    out_tag,
  output logic [topq_pkg::OCC_W-1:0]    out_occupancy
);
  import topq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t               state_r;
  state_t               state_nxt;
  op_t                  op_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic [CAPACITY-1:0]  le_r;
  logic [CAPACITY-1:0]  le_nxt;
  entry_t               store_r   [CAPACITY];
  entry_t               store_nxt [CAPACITY];
  logic                 exec_go;
  logic                 take;
  logic                 do_ins;
  logic                 do_del;
  status_t              status_nxt;
  entry_t               got;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [1:0]           status_r;
  entry_t               got_r;
  logic [CNT_W-1:0]     occ_r;

  // The result register is free when empty or being read this cycle.
  assign exec_go = !out_valid_r || out_ready;
  assign q_ready = (state_r == S_IDLE) || ((state_r == S_EXEC) && exec_go);
  assign take    = q_valid && q_ready;

  // Sequencer: take an operation, compare against the store, then execute.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt = take ? S_CMP : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Compare step: mark stored entries that sort at or before the new time.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      le_nxt[i] = (count_r > CNT_W'(i)) && (time_key(store_r[i]) <= time_key(op_r.entry));
    end
  end

  // Execute step: decide the outcome of the operation.
  always_comb begin
    status_nxt = ST_OK;
    count_nxt  = count_r;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    got        = '0;
    if (op_r.cmd == CMD_ENQ) begin
      if (op_r.bad_time) begin
        status_nxt = ST_BAD_TIME;
      end else if (count_r == CNT_FULL) begin
        status_nxt = ST_FULL;
      end else begin
        do_ins    = 1'b1;
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (count_r == '0) begin
        status_nxt = ST_EMPTY;
      end else begin
        do_del    = 1'b1;
        got       = store_r[0];
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  // Store update: insert behind all earlier-or-equal entries, or shift out the head.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      store_nxt[i] = store_r[i];
    end
    if (do_ins) begin
      if (!le_r[0]) begin
        store_nxt[0] = op_r.entry;
      end
      for (int i = 1; i < CAPACITY; i++) begin
        if (!le_r[i]) begin
          store_nxt[i] = le_r[i-1] ? op_r.entry : store_r[i-1];
        end
      end
    end else if (do_del) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        store_nxt[i] = store_r[i+1];
      end
    end
  end

  // Result valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if ((state_r == S_EXEC) && exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if ((state_r == S_EXEC) && exec_go) begin
        count_r <= count_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take) begin
      op_r <= q_op;
    end
    if (state_r == S_CMP) begin
      le_r <= le_nxt;
    end
    if ((state_r == S_EXEC) && exec_go) begin
      for (int i = 0; i < CAPACITY; i++) begin
        store_r[i] <= store_nxt[i];
      end
      status_r <= status_nxt;
      got_r    <= got;
      occ_r    <= count_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_hour       = got_r.hour;
  assign out_minute     = got_r.minute;
  assign out_party_size = got_r.party;
  assign out_tag        = got_r.tag;
  assign out_occupancy  = OCC_W'(occ_r);

endmodule
